// ----- rtl/ttt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes for the timed task table: operation codes,
// status codes, the stored entry layout and the result record.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int PARAM_W  = 16;
    localparam int TICK_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONEREADY = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [PARAM_W-1:0] param;
        logic [TICK_W-1:0]  countdown;
        logic [TICK_W-1:0]  period;
        logic               ready;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                run_valid;
        logic [ID_W-1:0]     run_task_id;
        logic [PARAM_W-1:0]  run_param;
    } result_t;

endpackage

// ----- rtl/timed_task_table.sv -----
// ----------------------------------------------------------------------------
// timed_task_table
// Ordered table of timed tasks: add, remove, tick and dispatch, with the
// entries held in a single-port-write synchronous memory.
// ----------------------------------------------------------------------------
// channel  | direction | ports
// ---------+-----------+----------------------------------------------------
// s_       | in        | s_valid s_ready s_op s_task_id s_task_param
//          |           | s_first_delay s_reload_period
// m_       | out       | m_valid m_ready m_status m_run_valid m_run_task_id
//          |           | m_run_param
//
// one transaction at a time; each stored entry takes a memory read, then an
// evaluate or write back, and the result is registered once the walk ends;
// the next transaction is accepted once the result has moved to the output
// register; a removal costs no more, the shift resumes the walk
// reset is synchronous, active low; it empties the table, memory needs no clear
// the result register lets s_ready rise again while a result waits on m_ready;
// the next transaction stalls only at its own completion
// ----------------------------------------------------------------------------
module timed_task_table #(
    parameter int MAX_TASKS = ttt_pkg::MAX_TASKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttt_pkg::OP_W-1:0]      s_op,
    input  logic [ttt_pkg::ID_W-1:0]      s_task_id,
    input  logic [ttt_pkg::PARAM_W-1:0]   s_task_param,
    input  logic [ttt_pkg::TICK_W-1:0]    s_first_delay,
    input  logic [ttt_pkg::TICK_W-1:0]    s_reload_period,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttt_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_run_valid,
    output logic [ttt_pkg::ID_W-1:0]      m_run_task_id,
    output logic [ttt_pkg::PARAM_W-1:0]   m_run_param
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    ttt_pkg::entry_t   mem_wdata;
    ttt_pkg::entry_t   mem_rdata;

    logic              res_valid;
    logic              res_ready;
    ttt_pkg::result_t  res;

    logic              m_valid_reg, m_valid_next;
    ttt_pkg::result_t  out_reg;
    logic              load;

    ttt_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ttt_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .s_task_param    (s_task_param),
        .s_first_delay   (s_first_delay),
        .s_reload_period (s_reload_period),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_run_valid   = out_reg.run_valid;
    assign m_run_task_id = out_reg.run_task_id;
    assign m_run_param   = out_reg.run_param;

endmodule

// ----- rtl/ttt_mem.sv -----
// ----------------------------------------------------------------------------
// ttt_mem
// Task entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttt_mem #(
    parameter int DEPTH = ttt_pkg::MAX_TASKS_DEF,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  ttt_pkg::entry_t  wdata,
    input  logic [AW-1:0]    raddr,
    output ttt_pkg::entry_t  rdata
);

    ttt_pkg::entry_t mem [DEPTH];
    ttt_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ttt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer that walks the entry store for each transaction: id search,
// tick update, ready search, and the gap-closing shift after a removal or a one-shot dispatch.
// ----------------------------------------------------------------------------
module ttt_ctrl #(
    parameter int MAX_TASKS = ttt_pkg::MAX_TASKS_DEF,
    parameter int AW        = 3,
    parameter int CW        = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttt_pkg::OP_W-1:0]      s_op,
    input  logic [ttt_pkg::ID_W-1:0]      s_task_id,
    input  logic [ttt_pkg::PARAM_W-1:0]   s_task_param,
    input  logic [ttt_pkg::TICK_W-1:0]    s_first_delay,
    input  logic [ttt_pkg::TICK_W-1:0]    s_reload_period,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ttt_pkg::result_t              res,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output ttt_pkg::entry_t               mem_wdata,
    output logic [AW-1:0]                 mem_raddr,
    input  ttt_pkg::entry_t               mem_rdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_EVAL     = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [ttt_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ttt_pkg::ID_W-1:0]      id_reg, id_next;
    logic [ttt_pkg::PARAM_W-1:0]   param_reg, param_next;
    logic [ttt_pkg::TICK_W-1:0]    delay_reg, delay_next;
    logic [ttt_pkg::TICK_W-1:0]    period_reg, period_next;
    ttt_pkg::result_t              res_reg, res_next;

    logic [CW-1:0]                 idx_inc;
    logic [CW-1:0]                 idx_prev;
    logic                          in_range;
    logic [ttt_pkg::TICK_W-1:0]    cd_dec;
    ttt_pkg::entry_t               ticked;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_prev = idx_reg - CW'(1);
    assign in_range = (idx_reg < count_reg);
    assign cd_dec   = mem_rdata.countdown - ttt_pkg::TICK_W'(1);

    // countdown step for one entry
    always_comb begin
        ticked = mem_rdata;
        if (mem_rdata.countdown != '0) begin
            ticked.countdown = cd_dec;
            if (cd_dec == '0) begin
                ticked.ready = 1'b1;
                if (mem_rdata.period != '0) begin
                    ticked.countdown = mem_rdata.period;
                end
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        param_next  = param_reg;
        delay_next  = delay_reg;
        period_next = period_reg;
        res_next    = res_reg;
        s_ready     = (state_reg == S_IDLE);
        res_valid   = (state_reg == S_DONE);
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    id_next     = s_task_id;
                    param_next  = s_task_param;
                    delay_next  = s_first_delay;
                    period_next = s_reload_period;
                    idx_next    = '0;
                    res_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (in_range) begin
                    state_next = S_EVAL;
                end else begin
                    // walk finished without an early exit
                    case (op_reg)
                        ttt_pkg::OP_ADD: begin
                            if (count_reg == CW'(MAX_TASKS)) begin
                                res_next.status = ttt_pkg::ST_FULL;
                            end else begin
                                mem_we              = 1'b1;
                                mem_waddr           = count_reg[AW-1:0];
                                mem_wdata.task_id   = id_reg;
                                mem_wdata.param     = param_reg;
                                mem_wdata.countdown = delay_reg;
                                mem_wdata.period    = period_reg;
                                mem_wdata.ready     = 1'b0;
                                count_next          = count_reg + CW'(1);
                            end
                        end
                        ttt_pkg::OP_REMOVE:   res_next.status = ttt_pkg::ST_NOTFOUND;
                        ttt_pkg::OP_DISPATCH: res_next.status = ttt_pkg::ST_NONEREADY;
                        default: ;
                    endcase
                    state_next = S_DONE;
                end
            end
            S_EVAL: begin
                idx_next   = idx_inc;
                state_next = S_SCAN;
                case (op_reg)
                    ttt_pkg::OP_ADD: begin
                        if (mem_rdata.task_id == id_reg) begin
                            res_next.status = ttt_pkg::ST_DUP;
                            state_next      = S_DONE;
                        end
                    end
                    ttt_pkg::OP_REMOVE: begin
                        if (mem_rdata.task_id == id_reg) begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    ttt_pkg::OP_TICK: begin
                        mem_we    = 1'b1;
                        mem_wdata = ticked;
                    end
                    ttt_pkg::OP_DISPATCH: begin
                        if (mem_rdata.ready) begin
                            res_next.run_valid   = 1'b1;
                            res_next.run_task_id = mem_rdata.task_id;
                            res_next.run_param   = mem_rdata.param;
                            if (mem_rdata.period != '0) begin
                                mem_we          = 1'b1;
                                mem_wdata.ready = 1'b0;
                                state_next      = S_DONE;
                            end else begin
                                // one-shot entry leaves the table
                                state_next = S_SHIFT_RD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT_RD: begin
                if (in_range) begin
                    state_next = S_SHIFT_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                // move entry idx down one slot
                mem_we     = 1'b1;
                mem_waddr  = idx_prev[AW-1:0];
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        param_reg  <= param_next;
        delay_reg  <= delay_next;
        period_reg <= period_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/ttt_checker.sv -----
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks for the timed task table, bound to the top level.
// ----------------------------------------------------------------------------
module ttt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ttt_pkg::STATUS_W-1:0]  m_status,
    input logic                          m_run_valid,
    input logic [ttt_pkg::ID_W-1:0]      m_run_task_id,
    input logic [ttt_pkg::PARAM_W-1:0]   m_run_param
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_run_valid)
            && $stable(m_run_task_id) && $stable(m_run_param))
        else $error("result changed while stalled");

    // a dispatched task always reports ok
    a_run_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_valid |-> m_status == ttt_pkg::ST_OK)
        else $error("run_valid with non-ok status");

    // no task fields without a dispatch
    a_run_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_valid |-> m_run_task_id == '0 && m_run_param == '0)
        else $error("task fields set without run_valid");

    // an accepted transaction leaves the block busy, so inputs are never accepted back to back
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

endmodule

bind timed_task_table ttt_checker u_ttt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_run_valid   (m_run_valid),
    .m_run_task_id (m_run_task_id),
    .m_run_param   (m_run_param)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed task table. A scoreboard model of the
// ordered task table predicts one result per transaction; directed traffic has
// random idle cycles on both channels, fill traffic none, random traffic each mix.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS       = ttt_pkg::MAX_TASKS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int CHUNKS      = 8;
    localparam int CHUNK_ITEMS = 200;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [ttt_pkg::OP_W-1:0]     s_op;
    logic [ttt_pkg::ID_W-1:0]     s_task_id;
    logic [ttt_pkg::PARAM_W-1:0]  s_task_param;
    logic [ttt_pkg::TICK_W-1:0]   s_first_delay;
    logic [ttt_pkg::TICK_W-1:0]   s_reload_period;
    logic                         m_valid;
    logic                         m_ready;
    logic [ttt_pkg::STATUS_W-1:0] m_status;
    logic                         m_run_valid;
    logic [ttt_pkg::ID_W-1:0]     m_run_task_id;
    logic [ttt_pkg::PARAM_W-1:0]  m_run_param;

    timed_task_table dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .s_task_param    (s_task_param),
        .s_first_delay   (s_first_delay),
        .s_reload_period (s_reload_period),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_run_valid     (m_run_valid),
        .m_run_task_id   (m_run_task_id),
        .m_run_param     (m_run_param)
    );

    // scoreboard copy of the task table
    ttt_pkg::entry_t  sched_slots [SLOTS];
    int               sched_count;
    ttt_pkg::result_t due_results [$];

    bit send_idle;
    bit recv_idle;
    int mismatch_count;
    int sent_count;
    int checked_count;
    int run_count;
    int status_seen [8];
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic logic [ttt_pkg::TICK_W-1:0] rand_word(input int lo, input int hi);
        return ttt_pkg::TICK_W'($urandom_range(lo, hi));
    endfunction

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < sched_count; i++)
            sched_slots[i] = sched_slots[i + 1];
        sched_count--;
    endfunction

    function automatic ttt_pkg::result_t apply_to_schedule(
        input logic [ttt_pkg::OP_W-1:0]    op,
        input logic [ttt_pkg::ID_W-1:0]    id,
        input logic [ttt_pkg::PARAM_W-1:0] param,
        input logic [ttt_pkg::TICK_W-1:0]  delay,
        input logic [ttt_pkg::TICK_W-1:0]  period
    );
        ttt_pkg::result_t res;
        int               hit;
        res = '0;
        res.status = ttt_pkg::ST_OK;
        hit = -1;
        for (int i = sched_count - 1; i >= 0; i--)
            if (sched_slots[i].task_id == id) hit = i;
        case (op)
            ttt_pkg::OP_ADD: begin
                if (hit >= 0) begin
                    res.status = ttt_pkg::ST_DUP;
                end else if (sched_count >= SLOTS) begin
                    res.status = ttt_pkg::ST_FULL;
                end else begin
                    sched_slots[sched_count].task_id   = id;
                    sched_slots[sched_count].param     = param;
                    sched_slots[sched_count].countdown = delay;
                    sched_slots[sched_count].period    = period;
                    sched_slots[sched_count].ready     = 1'b0;
                    sched_count++;
                end
            end
            ttt_pkg::OP_REMOVE: begin
                if (hit >= 0) drop_entry(hit);
                else res.status = ttt_pkg::ST_NOTFOUND;
            end
            ttt_pkg::OP_TICK: begin
                for (int i = 0; i < sched_count; i++) begin
                    if (sched_slots[i].countdown != '0) begin
                        sched_slots[i].countdown = sched_slots[i].countdown - 1'b1;
                        // expiry: mark stays set if already pending, one-shot reloads 0
                        if (sched_slots[i].countdown == '0) begin
                            sched_slots[i].ready     = 1'b1;
                            sched_slots[i].countdown = sched_slots[i].period;
                        end
                    end
                end
            end
            default: begin
                hit = -1;
                for (int i = sched_count - 1; i >= 0; i--)
                    if (sched_slots[i].ready) hit = i;
                if (hit < 0) begin
                    res.status = ttt_pkg::ST_NONEREADY;
                end else begin
                    res.run_valid   = 1'b1;
                    res.run_task_id = sched_slots[hit].task_id;
                    res.run_param   = sched_slots[hit].param;
                    sched_slots[hit].ready = 1'b0;
                    if (sched_slots[hit].period == '0) drop_entry(hit);
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_request(
        input logic [ttt_pkg::OP_W-1:0]    op,
        input logic [ttt_pkg::ID_W-1:0]    id,
        input logic [ttt_pkg::PARAM_W-1:0] param,
        input logic [ttt_pkg::TICK_W-1:0]  delay,
        input logic [ttt_pkg::TICK_W-1:0]  period
    );
        int gap;
        gap = draw_gap(send_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_task_id       <= id;
        s_task_param    <= param;
        s_first_delay   <= delay;
        s_reload_period <= period;
        do @(posedge aclk); while (!s_ready);
        due_results.push_back(apply_to_schedule(op, id, param, delay, period));
        sent_count++;
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_results_drained();
        if (due_results.size() != 0) begin
            s_valid <= 1'b0;
            while (due_results.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic check_result();
        ttt_pkg::result_t want;
        checked_count++;
        if (due_results.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        if (m_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_status, want.status));
        if (m_run_valid !== want.run_valid)
            report_mismatch($sformatf("run_valid %0b, expected %0b",
                                      m_run_valid, want.run_valid));
        if (m_run_task_id !== want.run_task_id)
            report_mismatch($sformatf("run_task_id %0h, expected %0h",
                                      m_run_task_id, want.run_task_id));
        if (m_run_param !== want.run_param)
            report_mismatch($sformatf("run_param %0h, expected %0h",
                                      m_run_param, want.run_param));
        if (want.run_valid) run_count++;
        status_seen[want.status]++;
    endtask

    // result side: random stall before each transaction when recv_idle is set
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_gap(recv_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_result();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [ttt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return ttt_pkg::ID_W'($urandom_range(0, 11) * 21);
        return ttt_pkg::ID_W'($urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_REMOVE,   8'h5A, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_ADD,      8'h00, 16'h0000, 16'h0001, 16'h0000);
        send_request(ttt_pkg::OP_ADD,      8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(ttt_pkg::OP_ADD,      8'h00, 16'h1234, 16'h0002, 16'h0002);
        // zero first delay: stored but never fires
        send_request(ttt_pkg::OP_ADD,      8'h10, 16'hAAAA, 16'h0000, 16'h0003);
        send_request(ttt_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        // periodic task expiring twice before dispatch collapses into one run
        send_request(ttt_pkg::OP_ADD,      8'h01, 16'h5555, 16'h0001, 16'h0001);
        send_request(ttt_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        // remove while ready drops the pending run
        send_request(ttt_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_REMOVE,   8'h01, 16'h0000, 16'h0000, 16'h0000);
        send_request(ttt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_request(ttt_pkg::OP_ADD, ttt_pkg::ID_W'(32'h20 + i), 16'h8000 >> i,
                         16'h0003, 16'h0004);
        send_request(ttt_pkg::OP_ADD,      8'h77, 16'h0F0F, 16'h0001, 16'h0001);
        // duplicate while full reports the duplicate
        send_request(ttt_pkg::OP_ADD,      8'h10, 16'hF0F0, 16'h0001, 16'h0001);
    endtask

    task automatic test_fill_cycle();
        logic [ttt_pkg::ID_W-1:0] held_ids [$];
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int i = 0; i < sched_count; i++)
            held_ids.push_back(sched_slots[i].task_id);
        foreach (held_ids[i])
            send_request(ttt_pkg::OP_REMOVE, held_ids[i], 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < SLOTS; i++)
            send_request(ttt_pkg::OP_ADD, ttt_pkg::ID_W'(32'h40 + i * 19),
                         rand_word(0, 65535), rand_word(1, 3),
                         (i % 3 == 0) ? 16'h0000 : rand_word(1, 4));
        send_request(ttt_pkg::OP_ADD, 8'hEE, 16'h0000, 16'h0001, 16'h0000);
        for (int i = 0; i < 40; i++)
            send_request($urandom_range(0, 1) ? ttt_pkg::OP_TICK : ttt_pkg::OP_DISPATCH,
                         8'h00, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic();
        int                          pick;
        logic [ttt_pkg::TICK_W-1:0]  delay;
        logic [ttt_pkg::TICK_W-1:0]  period;
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            send_idle = chunk[0];
            recv_idle = chunk[1];
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       delay = '0;
                    1:       delay = rand_word(0, 65535);
                    default: delay = rand_word(1, 6);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: period = '0;
                    4:          period = rand_word(0, 65535);
                    default:    period = rand_word(1, 8);
                endcase
                if (pick < 28)
                    send_request(ttt_pkg::OP_ADD, pick_id(), rand_word(0, 65535),
                                 delay, period);
                else if (pick < 42)
                    send_request(ttt_pkg::OP_REMOVE, pick_id(), rand_word(0, 65535),
                                 delay, period);
                else if (pick < 72)
                    send_request(ttt_pkg::OP_TICK, ttt_pkg::ID_W'($urandom_range(0, 255)),
                                 rand_word(0, 65535), delay, period);
                else
                    send_request(ttt_pkg::OP_DISPATCH,
                                 ttt_pkg::ID_W'($urandom_range(0, 255)),
                                 rand_word(0, 65535), delay, period);
            end
            wait_results_drained();
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_op            <= ttt_pkg::OP_TICK;
        s_task_id       <= '0;
        s_task_param    <= '0;
        s_first_delay   <= '0;
        s_reload_period <= '0;
        sched_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        wait_results_drained();
        test_fill_cycle();
        wait_results_drained();
        test_random_traffic();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d transactions, %0d results checked, %0d tasks dispatched",
                 sent_count, checked_count, run_count);
        $display("status mix: ok %0d, duplicate %0d, full %0d, not found %0d, none ready %0d",
                 status_seen[ttt_pkg::ST_OK], status_seen[ttt_pkg::ST_DUP],
                 status_seen[ttt_pkg::ST_FULL], status_seen[ttt_pkg::ST_NOTFOUND],
                 status_seen[ttt_pkg::ST_NONEREADY]);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ttt_pkg.sv
rtl/ttt_mem.sv
rtl/ttt_ctrl.sv
rtl/timed_task_table.sv
rtl/ttt_checker.sv
test/tb_top.sv
